// ===== sv/hrgbw_pkg.sv =====
`default_nettype none

package hrgbw_pkg;

  // Full-scale drive level and the level steps used by the color wheel
  localparam logic [15:0] LVL_FULL = 16'd65535;
  localparam logic [15:0] LVL_TWO3 = 16'd43690;
  localparam logic [15:0] LVL_ONE3 = 16'd21845;
  localparam logic [15:0] LVL_ZERO = 16'd0;

  // Segment spans; the reciprocal multiply divides by them
  localparam int RecipShift = 29;
  localparam int SpanA      = 8191;
  localparam int SpanB      = 8192;
  localparam int SpanC      = 7923;
  localparam int SpanD      = 8461;

  localparam logic [16:0] RECIP_A = 17'((64'd1 << RecipShift) / SpanA);
  localparam logic [16:0] RECIP_B = 17'((64'd1 << RecipShift) / SpanB);
  localparam logic [16:0] RECIP_C = 17'((64'd1 << RecipShift) / SpanC);
  localparam logic [16:0] RECIP_D = 17'((64'd1 << RecipShift) / SpanD);

  localparam int ProdW = 29;   // |slope| * hue offset stays below 2**29
  localparam int DhW   = 14;   // hue offset inside a segment
  localparam int DenW  = 14;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2
  } chan_sel_e;

  typedef enum logic [2:0] {
    CFG_WHITE_EN   = 3'd0,
    CFG_MAX_PWR    = 3'd1,
    CFG_CAL_EN     = 3'd2,
    CFG_GREEN_GAIN = 3'd3,
    CFG_BLUE_GAIN  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0]     top;
    logic [15:0]     h1;
    logic [DenW-1:0] den;
    logic [16:0]     recip;
    chan_sel_e       ch_a;
    logic [15:0]     a1;
    logic [15:0]     a_mag;
    logic            a_neg;
    chan_sel_e       ch_b;
    logic [15:0]     b1;
    logic [15:0]     b_mag;
    logic            b_neg;
  } seg_t;

  typedef struct packed {
    logic        white_en;
    logic        max_pwr;
    logic        cal_en;
    logic [15:0] green_gain;
    logic [15:0] blue_gain;
  } cfg_t;

  // Interpolated magnitudes leaving the wheel pipeline
  typedef struct packed {
    logic [2:0]  seg;
    logic [15:0] q_a;
    logic [15:0] q_b;
    logic [15:0] sat;
    logic [15:0] bri;
  } interp_t;

  function automatic seg_t seg_info(input logic [2:0] k);
    seg_t s;
    unique case (k)
      3'd0: s = '{16'd8191,  16'd0,     DenW'(SpanA), RECIP_A,
                  CH_RED,   LVL_FULL, LVL_ONE3, 1'b1, CH_GREEN, LVL_ZERO, LVL_ONE3, 1'b0};
      3'd1: s = '{16'd16383, 16'd8191,  DenW'(SpanB), RECIP_B,
                  CH_RED,   LVL_TWO3, LVL_ZERO, 1'b0, CH_GREEN, LVL_ONE3, LVL_ONE3, 1'b0};
      3'd2: s = '{16'd24575, 16'd16383, DenW'(SpanB), RECIP_B,
                  CH_RED,   LVL_TWO3, LVL_TWO3, 1'b1, CH_GREEN, LVL_TWO3, LVL_ONE3, 1'b0};
      3'd3: s = '{16'd32767, 16'd24575, DenW'(SpanB), RECIP_B,
                  CH_GREEN, LVL_FULL, LVL_ONE3, 1'b1, CH_BLUE,  LVL_ZERO, LVL_ONE3, 1'b0};
      3'd4: s = '{16'd40689, 16'd32767, DenW'(SpanC), RECIP_C,
                  CH_GREEN, LVL_TWO3, LVL_TWO3, 1'b1, CH_BLUE,  LVL_ONE3, LVL_TWO3, 1'b0};
      3'd5: s = '{16'd49151, 16'd40690, DenW'(SpanD), RECIP_D,
                  CH_BLUE,  LVL_FULL, LVL_ONE3, 1'b1, CH_RED,   LVL_ZERO, LVL_ONE3, 1'b0};
      3'd6: s = '{16'd57343, 16'd49151, DenW'(SpanB), RECIP_B,
                  CH_BLUE,  LVL_TWO3, LVL_ONE3, 1'b1, CH_RED,   LVL_ONE3, LVL_ONE3, 1'b0};
      3'd7: s = '{16'd65535, 16'd57343, DenW'(SpanB), RECIP_B,
                  CH_BLUE,  LVL_ONE3, LVL_ONE3, 1'b1, CH_RED,   LVL_TWO3, LVL_ONE3, 1'b0};
    endcase
    return s;
  endfunction

  // Unsigned 16x16 product keeping the upper half
  function automatic logic [15:0] scale16(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] p;
    p = {16'd0, a} * {16'd0, b};
    return p[31:16];
  endfunction

endpackage

`default_nettype wire

// ===== sv/hrgbw_wheel.sv =====
`default_nettype none

// Segment pick and per-segment linear interpolation, four register stages:
// segment/offset, slope products, reciprocal quotient estimate, correction.
module hrgbw_wheel (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [15:0]         hue_i,
  input  wire logic [15:0]         sat_i,
  input  wire logic [15:0]         bri_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output hrgbw_pkg::interp_t       out_o
);
  import hrgbw_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  // stage 1
  logic [2:0]     seg_d, seg1_q;
  logic [DhW-1:0] dh1_q;
  logic [15:0]    sat1_q, bri1_q;
  seg_t           sg0;

  // stage 2
  logic [2:0]       seg2_q;
  logic [ProdW-1:0] pa2_q, pb2_q;
  logic [15:0]      sat2_q, bri2_q;
  seg_t             sg1;

  // stage 3
  logic [2:0]       seg3_q;
  logic [ProdW-1:0] pa3_q, pb3_q;
  logic [15:0]      qea3_q, qeb3_q, sat3_q, bri3_q;
  logic [ProdW+16:0] ea, eb;
  seg_t             sg2;

  // stage 4
  logic [2:0]       seg4_q;
  logic [15:0]      qa4_q, qb4_q, sat4_q, bri4_q;
  logic [ProdW-1:0] ra, rb;
  seg_t             sg3;

  // advance a stage when it is empty or the next one moves
  assign en4        = ~v4_q | out_ready_i;
  assign en3        = ~v3_q | en4;
  assign en2        = ~v2_q | en3;
  assign en1        = ~v1_q | en2;
  assign in_ready_o = en1;

  always_comb begin
    seg_d = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (hue_i <= seg_info(3'(i)).top) begin
        seg_d = 3'(i);
      end
    end
    sg0 = seg_info(seg_d);
    sg1 = seg_info(seg1_q);
    sg2 = seg_info(seg2_q);
    sg3 = seg_info(seg3_q);
    ea  = (ProdW+17)'(pa2_q) * (ProdW+17)'(sg2.recip);
    eb  = (ProdW+17)'(pb2_q) * (ProdW+17)'(sg2.recip);
    ra  = pa3_q - ProdW'({13'd0, qea3_q} * {15'd0, sg3.den});
    rb  = pb3_q - ProdW'({13'd0, qeb3_q} * {15'd0, sg3.den});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      seg1_q <= seg_d;
      dh1_q  <= DhW'(hue_i - sg0.h1);
      sat1_q <= sat_i;
      bri1_q <= bri_i;
    end
    if (en2 && v1_q) begin
      seg2_q <= seg1_q;
      pa2_q  <= ProdW'({16'd0, dh1_q} * {{DhW{1'b0}}, sg1.a_mag});
      pb2_q  <= ProdW'({16'd0, dh1_q} * {{DhW{1'b0}}, sg1.b_mag});
      sat2_q <= sat1_q;
      bri2_q <= bri1_q;
    end
    if (en3 && v2_q) begin
      seg3_q <= seg2_q;
      pa3_q  <= pa2_q;
      pb3_q  <= pb2_q;
      // estimate is exact or one short
      qea3_q <= ea[RecipShift+15:RecipShift];
      qeb3_q <= eb[RecipShift+15:RecipShift];
      sat3_q <= sat2_q;
      bri3_q <= bri2_q;
    end
    if (en4 && v3_q) begin
      seg4_q <= seg3_q;
      qa4_q  <= (ra >= ProdW'(sg3.den)) ? qea3_q + 16'd1 : qea3_q;
      qb4_q  <= (rb >= ProdW'(sg3.den)) ? qeb3_q + 16'd1 : qeb3_q;
      sat4_q <= sat3_q;
      bri4_q <= bri3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign out_o       = '{seg: seg4_q, q_a: qa4_q, q_b: qb4_q, sat: sat4_q, bri: bri4_q};

endmodule

`default_nettype wire

// ===== sv/hrgbw_scale.sv =====
`default_nettype none

// Channel assembly, saturation, calibration gains and brightness,
// four register stages; the last one is the output register.
module hrgbw_scale (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hrgbw_pkg::cfg_t    cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire hrgbw_pkg::interp_t in_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [15:0]             red_o,
  output logic [15:0]             green_o,
  output logic [15:0]             blue_o,
  output logic [15:0]             white_o
);
  import hrgbw_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  seg_t             sg;
  logic [15:0]      val_a, val_b;
  logic [2:0][15:0] c_d, c1_q, c2_d, c2_q, c3_q;
  logic [15:0]      floor1_q, floor2_q, floor3_q;
  logic [15:0]      sat1_q;
  logic [15:0]      bri1_q, bri2_q, bri3_q;
  logic [15:0]      red4_q, green4_q, blue4_q, white4_q;

  assign en4        = ~v4_q | out_ready_i;
  assign en3        = ~v3_q | en4;
  assign en2        = ~v2_q | en3;
  assign en1        = ~v1_q | en2;
  assign in_ready_o = en1;

  always_comb begin
    sg    = seg_info(in_i.seg);
    val_a = sg.a_neg ? sg.a1 - in_i.q_a : sg.a1 + in_i.q_a;
    val_b = sg.b_neg ? sg.b1 - in_i.q_b : sg.b1 + in_i.q_b;
    for (int i = 0; i < 3; i++) begin
      if (sg.ch_a == chan_sel_e'(i)) begin
        c_d[i] = val_a;
      end else if (sg.ch_b == chan_sel_e'(i)) begin
        c_d[i] = val_b;
      end else begin
        c_d[i] = 16'd0;
      end
    end
    // scale by saturation in plain RGBW, otherwise raise to the floor
    for (int i = 0; i < 3; i++) begin
      if (cfg_i.white_en && !cfg_i.max_pwr) begin
        c2_d[i] = scale16(c1_q[i], sat1_q);
      end else if (c1_q[i] < floor1_q) begin
        c2_d[i] = floor1_q;
      end else begin
        c2_d[i] = c1_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      c1_q     <= c_d;
      sat1_q   <= in_i.sat;
      floor1_q <= ~in_i.sat;
      bri1_q   <= in_i.bri;
    end
    if (en2 && v1_q) begin
      c2_q     <= c2_d;
      floor2_q <= floor1_q;
      bri2_q   <= bri1_q;
    end
    if (en3 && v2_q) begin
      c3_q[0]  <= c2_q[0];
      c3_q[1]  <= cfg_i.cal_en ? scale16(c2_q[1], cfg_i.green_gain) : c2_q[1];
      c3_q[2]  <= cfg_i.cal_en ? scale16(c2_q[2], cfg_i.blue_gain) : c2_q[2];
      floor3_q <= floor2_q;
      bri3_q   <= bri2_q;
    end
    if (en4 && v3_q) begin
      red4_q   <= scale16(c3_q[0], bri3_q);
      green4_q <= scale16(c3_q[1], bri3_q);
      blue4_q  <= scale16(c3_q[2], bri3_q);
      white4_q <= cfg_i.white_en ? scale16(floor3_q, bri3_q) : 16'd0;
    end
  end

  assign out_valid_o = v4_q;
  assign red_o       = red4_q;
  assign green_o     = green4_q;
  assign blue_o      = blue4_q;
  assign white_o     = white4_q;

endmodule

`default_nettype wire

// ===== sv/hsv_to_rgbw_led_color_core.sv =====
// HSV to RGBW converter for LED drive levels, 16 bits per channel.
// Input stream (s_axis): one beat per pixel, tdata = hue, saturation,
// brightness from the lowest bit up. Output stream (m_axis): one beat per
// pixel, tdata = red, green, blue, white from the lowest bit up.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i at the
// clock edge (0 white enable, 1 max-power saturation, 2 calibration enable,
// 3 green gain, 4 blue gain); other indexes are dropped. Write only while
// the pipeline is empty.
// Eight register stages lie between an accepted input beat and its output
// beat (segment pick, slope multiply, reciprocal estimate, quotient fix,
// channel assembly, saturation, gains, brightness). Throughput: one pixel
// per clock while m_axis_tready is high; every stage holds its own valid bit.
// When m_axis_tready is low, full stages hold and bubbles still close up,
// so input is taken until the pipeline is full; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults: RGB mode,
// no max-power saturation, calibration off, both gains at 65535.
`default_nettype none

module hsv_to_rgbw_led_color_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  // pixel input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,   // hue[15:0], saturation[31:16], brightness[47:32]
  // pixel output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata    // red[15:0], green[31:16], blue[47:32], white[63:48]
);
  import hrgbw_pkg::*;

  cfg_t    cfg_q;
  interp_t mid;
  logic    mid_valid, mid_ready;
  logic [15:0] red, green, blue, white;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{white_en: 1'b0, max_pwr: 1'b0, cal_en: 1'b0,
                 green_gain: LVL_FULL, blue_gain: LVL_FULL};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WHITE_EN:   cfg_q.white_en   <= cfg_data_i[0];
        CFG_MAX_PWR:    cfg_q.max_pwr    <= cfg_data_i[0];
        CFG_CAL_EN:     cfg_q.cal_en     <= cfg_data_i[0];
        CFG_GREEN_GAIN: cfg_q.green_gain <= cfg_data_i;
        CFG_BLUE_GAIN:  cfg_q.blue_gain  <= cfg_data_i;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // Hue wheel: pick the segment and interpolate its two channels
  hrgbw_wheel u_wheel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .hue_i       (s_axis_tdata[15:0]),
    .sat_i       (s_axis_tdata[31:16]),
    .bri_i       (s_axis_tdata[47:32]),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_o       (mid)
  );

  // Saturation, calibration and brightness; ends in the output register
  hrgbw_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_i        (mid),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue),
    .white_o     (white)
  );

  assign m_axis_tdata = {white, blue, green, red};

endmodule

`default_nettype wire
